// ===== sv/gbr_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers for the glyph box renderer
// no dependencies

package gbr_pkg;

  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned BORDER_W   = 8;
  localparam int unsigned VIS_W_W    = 10;
  localparam int unsigned VIS_H_W    = 9;
  localparam int unsigned REGION_H_W = 10;
  localparam int unsigned COUNT_W    = 10;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam int unsigned FRAME_WIDTH_DEF  = 640;
  localparam int unsigned FRAME_HEIGHT_DEF = 480;

  localparam logic [COLOR_W-1:0]    FONT_COLOR_RST     = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0]    FILL_COLOR_RST     = 32'h0000_0000;
  localparam logic [COLOR_W-1:0]    LINE_COLOR_RST     = 32'h0000_0000;
  localparam logic                  FILL_BACKGROUND_RST = 1'b0;
  localparam logic [BORDER_W-1:0]   BORDER_WIDTH_RST   = 8'd0;
  localparam logic [VIS_W_W-1:0]    VISIBLE_WIDTH_RST  = 10'd640;
  localparam logic [VIS_H_W-1:0]    VISIBLE_HEIGHT_RST = 9'd480;
  localparam logic [REGION_H_W-1:0] REGION_HEIGHT_RST  = 10'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FONT_COLOR      = 3'd0,
    REG_FILL_COLOR      = 3'd1,
    REG_LINE_COLOR      = 3'd2,
    REG_FILL_BACKGROUND = 3'd3,
    REG_BORDER_WIDTH    = 3'd4,
    REG_VISIBLE_WIDTH   = 3'd5,
    REG_VISIBLE_HEIGHT  = 3'd6,
    REG_REGION_HEIGHT   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [COLOR_W-1:0]    font_color;
    logic [COLOR_W-1:0]    fill_color;
    logic [COLOR_W-1:0]    line_color;
    logic                  fill_background;
    logic [BORDER_W-1:0]   border_width;
    logic [VIS_W_W-1:0]    visible_width;
    logic [VIS_H_W-1:0]    visible_height;
    logic [REGION_H_W-1:0] region_height;
  } cfg_t;

  // raster position of the pixel being rendered
  typedef struct packed {
    logic [COUNT_W-1:0] col;
    logic [COUNT_W-1:0] row;
    logic [COUNT_W-1:0] width;
    logic               row_end;
    logic               region_end;
  } pos_t;

  // zero reads as one, oversize saturates at the frame size
  function automatic logic [COUNT_W-1:0] eff_limit(input logic [COUNT_W-1:0] v,
                                                   input logic [COUNT_W-1:0] top);
    logic [COUNT_W-1:0] res;
    if (v == '0) begin
      res = COUNT_W'(1);
    end else if (v > top) begin
      res = top;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ===== sv/osd_glyph_box_renderer.sv =====
`timescale 1ns / 1ps
// top level of the glyph box renderer: config registers, raster counters, color pipe
// depends on gbr_pkg, gbr_cfg_regs, gbr_raster_pos, gbr_color_pipe

// Renders the visible pixels of one text box, one word per pixel in row-major
// order. Each input word carries a glyph bit and the background ARGB pixel; the
// result word carries the ARGB pixel plus end-of-row and end-of-region flags.
// Ink pixels take font_color, other pixels take fill_color when fill_background
// is set and keep the background otherwise; with a nonzero border_width the
// frame (top, left, bottom against region_height, right against the clipped
// width) is painted in line_color. Throughput is one pixel per clock unless
// result_stall holds the pipe; the pixel passes the input register, the color
// border logic and the result register. The raster counters advance once per
// pixel moved into the result register and reset to the top-left corner.
// Configuration words are taken every cycle (cfg_ready is always high) and
// should be written only while no pixel is in flight; index values select the
// registers in order font, fill, line color, fill enable, border width,
// visible width, visible height, region height.

module osd_glyph_box_renderer #(
  parameter int unsigned FRAME_WIDTH  = gbr_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = gbr_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbr_pkg::COLOR_W-1:0]   cfg_data,
  // pixel input channel
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  logic                          glyph_bit,
  input  logic [gbr_pkg::COLOR_W-1:0]   background_pixel,
  // result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [gbr_pkg::COLOR_W-1:0]   pixel_out,
  output logic                          row_end,
  output logic                          region_end
);

  gbr_pkg::cfg_t cfg;
  gbr_pkg::pos_t pos;
  logic          advance;

  // register file, written one word at a time
  gbr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // position of the pixel sitting in the input register
  gbr_raster_pos #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_pos (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cfg     (cfg),
    .pos     (pos)
  );

  // two-register pipe with color and border select in between
  gbr_color_pipe u_pipe (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .pos              (pos),
    .advance          (advance),
    .pixel_valid      (pixel_valid),
    .pixel_stall      (pixel_stall),
    .glyph_bit        (glyph_bit),
    .background_pixel (background_pixel),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .pixel_out        (pixel_out),
    .row_end          (row_end),
    .region_end       (region_end)
  );

endmodule

// ===== sv/gbr_cfg_regs.sv =====
`timescale 1ns / 1ps
// configuration register file of the glyph box renderer
// depends on gbr_pkg

module gbr_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbr_pkg::COLOR_W-1:0]    cfg_data,
  output gbr_pkg::cfg_t                  cfg
);

  gbr_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.font_color      <= gbr_pkg::FONT_COLOR_RST;
      regs.fill_color      <= gbr_pkg::FILL_COLOR_RST;
      regs.line_color      <= gbr_pkg::LINE_COLOR_RST;
      regs.fill_background <= gbr_pkg::FILL_BACKGROUND_RST;
      regs.border_width    <= gbr_pkg::BORDER_WIDTH_RST;
      regs.visible_width   <= gbr_pkg::VISIBLE_WIDTH_RST;
      regs.visible_height  <= gbr_pkg::VISIBLE_HEIGHT_RST;
      regs.region_height   <= gbr_pkg::REGION_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (gbr_pkg::reg_idx_t'(cfg_index))
        gbr_pkg::REG_FONT_COLOR:      regs.font_color      <= cfg_data;
        gbr_pkg::REG_FILL_COLOR:      regs.fill_color      <= cfg_data;
        gbr_pkg::REG_LINE_COLOR:      regs.line_color      <= cfg_data;
        gbr_pkg::REG_FILL_BACKGROUND: regs.fill_background <= cfg_data[0];
        gbr_pkg::REG_BORDER_WIDTH:
          regs.border_width <= cfg_data[gbr_pkg::BORDER_W-1:0];
        gbr_pkg::REG_VISIBLE_WIDTH:
          regs.visible_width <= cfg_data[gbr_pkg::VIS_W_W-1:0];
        gbr_pkg::REG_VISIBLE_HEIGHT:
          regs.visible_height <= cfg_data[gbr_pkg::VIS_H_W-1:0];
        gbr_pkg::REG_REGION_HEIGHT:
          regs.region_height <= cfg_data[gbr_pkg::REGION_H_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/gbr_raster_pos.sv =====
`timescale 1ns / 1ps
// column and row counters with end of row and end of region flags
// depends on gbr_pkg

module gbr_raster_pos #(
  parameter int unsigned FRAME_WIDTH  = gbr_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = gbr_pkg::FRAME_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  gbr_pkg::cfg_t cfg,
  output gbr_pkg::pos_t pos
);

  logic [gbr_pkg::COUNT_W-1:0] col;
  logic [gbr_pkg::COUNT_W-1:0] row;
  logic [gbr_pkg::COUNT_W-1:0] col_next;
  logic [gbr_pkg::COUNT_W-1:0] row_next;
  logic [gbr_pkg::COUNT_W-1:0] width;
  logic [gbr_pkg::COUNT_W-1:0] height;
  logic                        row_end;
  logic                        region_end;

  assign width  = gbr_pkg::eff_limit(cfg.visible_width,
                                     gbr_pkg::COUNT_W'(FRAME_WIDTH));
  assign height = gbr_pkg::eff_limit({1'b0, cfg.visible_height},
                                     gbr_pkg::COUNT_W'(FRAME_HEIGHT));

  // past-the-end counts (limits lowered mid-stream) also close the row
  assign row_end    = col >= (width - gbr_pkg::COUNT_W'(1));
  assign region_end = row_end && (row >= (height - gbr_pkg::COUNT_W'(1)));

  always_comb begin
    col_next = col;
    row_next = row;
    if (row_end) begin
      col_next = '0;
      row_next = region_end ? '0 : row + gbr_pkg::COUNT_W'(1);
    end else begin
      col_next = col + gbr_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (advance) begin
      col <= col_next;
      row <= row_next;
    end
  end

  assign pos.col        = col;
  assign pos.row        = row;
  assign pos.width      = width;
  assign pos.row_end    = row_end;
  assign pos.region_end = region_end;

  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    advance && row_end |=> col == '0)
    else $error("column did not wrap at end of row");

  a_col_step: assert property (@(posedge clk) disable iff (rst)
    advance && !row_end |=> col == $past(col) + gbr_pkg::COUNT_W'(1) && $stable(row))
    else $error("column step wrong inside a row");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(col) && $stable(row))
    else $error("position moved without a pixel");

  a_region_in_row: assert property (@(posedge clk) disable iff (rst)
    region_end |-> row_end)
    else $error("end of region off the end of a row");

endmodule

// ===== sv/gbr_color_pipe.sv =====
`timescale 1ns / 1ps
// input register, color and border selection, result register
// depends on gbr_pkg

module gbr_color_pipe (
  input  logic                        clk,
  input  logic                        rst,
  input  gbr_pkg::cfg_t               cfg,
  input  gbr_pkg::pos_t               pos,
  output logic                        advance,
  input  logic                        pixel_valid,
  output logic                        pixel_stall,
  input  logic                        glyph_bit,
  input  logic [gbr_pkg::COLOR_W-1:0] background_pixel,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [gbr_pkg::COLOR_W-1:0] pixel_out,
  output logic                        row_end,
  output logic                        region_end
);

  logic                        in_full;
  logic                        in_glyph;
  logic [gbr_pkg::COLOR_W-1:0] in_bg;
  logic                        out_free;
  logic                        on_border;
  logic [gbr_pkg::COLOR_W-1:0] base_color;
  logic [gbr_pkg::COLOR_W-1:0] pix_next;
  logic [gbr_pkg::COUNT_W:0]   row_plus_bw;
  logic [gbr_pkg::COUNT_W:0]   col_plus_bw;

  assign out_free    = !result_valid || !result_stall;
  assign advance     = in_full && out_free;
  assign pixel_stall = in_full && !out_free;

  // sums in one extra bit so the signed edge differences need no sign logic
  assign row_plus_bw = {1'b0, pos.row} + (gbr_pkg::COUNT_W+1)'(cfg.border_width);
  assign col_plus_bw = {1'b0, pos.col} + (gbr_pkg::COUNT_W+1)'(cfg.border_width);

  always_comb begin
    if (in_glyph) begin
      base_color = cfg.font_color;
    end else if (cfg.fill_background) begin
      base_color = cfg.fill_color;
    end else begin
      base_color = in_bg;
    end
    on_border = (cfg.border_width != '0) &&
                ((pos.row < gbr_pkg::COUNT_W'(cfg.border_width)) ||
                 ((gbr_pkg::COUNT_W+1)'(cfg.region_height) <= row_plus_bw) ||
                 (pos.col < gbr_pkg::COUNT_W'(cfg.border_width)) ||
                 ((gbr_pkg::COUNT_W+1)'(pos.width) <= col_plus_bw));
    pix_next = on_border ? cfg.line_color : base_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (!in_full || out_free) begin
        in_full <= pixel_valid;
      end
      if (out_free) begin
        result_valid <= in_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_valid && !pixel_stall) begin
      in_glyph <= glyph_bit;
      in_bg    <= background_pixel;
    end
    if (advance) begin
      pixel_out  <= pix_next;
      row_end    <= pos.row_end;
      region_end <= pos.region_end;
    end
  end

  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !in_full |-> !pixel_stall)
    else $error("stall raised with an empty input register");

  a_result_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(in_full))
    else $error("result appeared with no pixel behind it");

  a_region_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid && region_end |-> row_end)
    else $error("end of region flagged off the end of a row");

endmodule
